FILE: rtl/core/mbc_pkg.sv
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types, codes and address map of the memory bus with console decode.
// ----------------------------------------------------------------------------
package mbc_pkg;

  // RAM geometry: bytes are addressed with RAM_ADDR_BITS, words with two less
  localparam int unsigned RAM_ADDR_BITS  = 18;
  localparam int unsigned WORD_ADDR_BITS = RAM_ADDR_BITS - 2;
  localparam int unsigned RAM_WORDS      = 1 << WORD_ADDR_BITS;

  // Address map
  localparam logic [31:0] RAM_BASE = 32'h8000_0000;
  localparam logic [31:0] CON_CHAR = 32'h1000_0000;
  localparam logic [31:0] CON_DEC  = 32'h1000_0004;
  localparam logic [31:0] CON_HEX  = 32'h1000_0008;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_BAD  = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    FMT_CHAR = 2'd0,
    FMT_DEC  = 2'd1,
    FMT_HEX  = 2'd2
  } con_fmt_e;

  // RAM request produced by the decoder
  typedef struct packed {
    logic                      rd;
    logic                      we;
    logic [3:0]                be;
    logic [WORD_ADDR_BITS-1:0] widx;
    logic [31:0]               wdata;
  } ram_req_t;

  // Per-item control that travels with the RAM read
  typedef struct packed {
    logic        rd;
    size_e       size;
    logic [1:0]  lane;
    logic        fault;
    logic        con_valid;
    con_fmt_e    con_fmt;
    logic [31:0] con_value;
  } item_ctl_t;

endpackage

FILE: rtl/core/mbc_if.sv
// ----------------------------------------------------------------------------
// mbc_if
// Request and response channels of the memory bus (valid/ready handshake).
// ----------------------------------------------------------------------------
interface mbc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [1:0]  access_size;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, opcode, access_size, address, write_data, input ready);
  modport sink   (input valid, opcode, access_size, address, write_data, output ready);
endinterface

interface mbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        fault;
  logic        console_valid;
  logic [1:0]  console_format;
  logic [31:0] console_value;

  modport source (output valid, read_data, fault, console_valid, console_format,
                  console_value, input ready);
  modport sink   (input valid, read_data, fault, console_valid, console_format,
                  console_value, output ready);
endinterface

FILE: rtl/core/mbc_ram.sv
// ----------------------------------------------------------------------------
// mbc_ram
// Single-port word RAM with byte enables and a registered read port.
// ----------------------------------------------------------------------------
module mbc_ram (
  input  logic                               clk_i,
  input  logic                               re_i,
  input  logic                               we_i,
  input  logic [3:0]                         be_i,
  input  logic [mbc_pkg::WORD_ADDR_BITS-1:0] addr_i,
  input  logic [31:0]                        wdata_i,
  output logic [31:0]                        rdata_o
);

  logic [31:0] mem [mbc_pkg::RAM_WORDS];
  logic [31:0] rdata_q;

  // Write enabled byte lanes
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 4; b++) begin
        if (be_i[b]) begin
          mem[addr_i][8*b +: 8] <= wdata_i[8*b +: 8];
        end
      end
    end
  end

  // Read whole word, hold until next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mbc_decode.sv
// ----------------------------------------------------------------------------
// mbc_decode
// Address decode: console hits, RAM range, alignment, size and byte lanes.
// ----------------------------------------------------------------------------
module mbc_decode (
  input  logic                   opcode_i,
  input  logic [1:0]             access_size_i,
  input  logic [31:0]            address_i,
  input  logic [31:0]            write_data_i,
  output mbc_pkg::ram_req_t      ram_o,
  output mbc_pkg::item_ctl_t     ctl_o
);

  logic             is_con;
  logic             in_range;
  logic             aligned;
  logic             size_ok;
  logic             is_write;
  logic [1:0]       lane;
  mbc_pkg::size_e   size;
  logic [3:0]       be;
  logic [31:0]      wdata;

  assign size     = mbc_pkg::size_e'(access_size_i);
  assign is_write = (opcode_i == mbc_pkg::OP_WRITE);
  assign lane     = address_i[1:0];
  assign is_con   = (address_i == mbc_pkg::CON_CHAR) || (address_i == mbc_pkg::CON_DEC) ||
                    (address_i == mbc_pkg::CON_HEX);
  assign in_range = (address_i[31:mbc_pkg::RAM_ADDR_BITS] ==
                     mbc_pkg::RAM_BASE[31:mbc_pkg::RAM_ADDR_BITS]);

  // Size checks and byte lane placement
  always_comb begin
    aligned = 1'b1;
    size_ok = 1'b1;
    be      = 4'b0000;
    wdata   = write_data_i;
    case (size)
      mbc_pkg::SZ_BYTE: begin
        be    = 4'b0001 << lane;
        wdata = {4{write_data_i[7:0]}};
      end
      mbc_pkg::SZ_HALF: begin
        aligned = ~lane[0];
        be      = 4'b0011 << {lane[1], 1'b0};
        wdata   = {2{write_data_i[15:0]}};
      end
      mbc_pkg::SZ_WORD: begin
        aligned = (lane == 2'b00);
        be      = 4'b1111;
      end
      default: begin
        size_ok = 1'b0;
      end
    endcase
  end

  // RAM request
  assign ram_o.rd    = !is_con && in_range && aligned && size_ok && !is_write;
  assign ram_o.we    = !is_con && in_range && aligned && size_ok && is_write;
  assign ram_o.be    = be;
  assign ram_o.widx  = address_i[mbc_pkg::RAM_ADDR_BITS-1:2];
  assign ram_o.wdata = wdata;

  // Control carried to the response
  always_comb begin
    ctl_o.rd        = ram_o.rd;
    ctl_o.size      = size;
    ctl_o.lane      = lane;
    ctl_o.fault     = !is_con && (!in_range || !aligned || (!size_ok && !is_write));
    ctl_o.con_valid = is_con && is_write;
    ctl_o.con_fmt   = mbc_pkg::FMT_CHAR;
    ctl_o.con_value = 32'd0;
    if (is_con && is_write) begin
      ctl_o.con_value = write_data_i;
      if (address_i == mbc_pkg::CON_DEC) begin
        ctl_o.con_fmt = mbc_pkg::FMT_DEC;
      end else if (address_i == mbc_pkg::CON_HEX) begin
        ctl_o.con_fmt = mbc_pkg::FMT_HEX;
      end
    end
  end

endmodule

FILE: rtl/core/mbc_format.sv
// ----------------------------------------------------------------------------
// mbc_format
// Lane select and sign extension of the RAM read word.
// ----------------------------------------------------------------------------
module mbc_format (
  input  mbc_pkg::item_ctl_t ctl_i,
  input  logic [31:0]        word_i,
  output logic [31:0]        read_data_o
);

  logic [31:0] shifted;

  assign shifted = word_i >> {ctl_i.lane, 3'b000};

  // Pick the lane and extend the sign
  always_comb begin
    read_data_o = 32'd0;
    if (ctl_i.rd) begin
      case (ctl_i.size)
        mbc_pkg::SZ_BYTE: read_data_o = {{24{shifted[7]}}, shifted[7:0]};
        mbc_pkg::SZ_HALF: read_data_o = {{16{shifted[15]}}, shifted[15:0]};
        mbc_pkg::SZ_WORD: read_data_o = word_i;
        default:          read_data_o = 32'd0;
      endcase
    end
  end

endmodule

FILE: rtl/core/memory_bus_with_console_mmio.sv
// Path: an accepted request is registered in the access stage (RAM read
//   register), then in the output register, which holds it until it transfers.
// Throughput: one request per cycle while the response side takes results;
//   the single RAM port does one read or one byte-enabled write per item, so there is no read-modify-write.
// Reset: clears the stage and output valid flags; RAM content is undefined
//   until written and gets no clearing pass.
// ----------------------------------------------------------------------------
// memory_bus_with_console_mmio
// Bus front end: decode, RAM access stage and registered response.
// ----------------------------------------------------------------------------
module memory_bus_with_console_mmio (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbc_req_if.sink       req_i,
  mbc_rsp_if.source     rsp_o
);

  mbc_pkg::ram_req_t   dec_ram;
  mbc_pkg::item_ctl_t  dec_ctl;
  mbc_pkg::item_ctl_t  s1_ctl_q, s1_ctl_d;
  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         ram_rdata;
  logic [31:0]         fmt_rdata;
  logic                accept;
  logic                out_free;
  logic                advance;

  logic [31:0]         rdata_q, rdata_d;
  logic                fault_q, fault_d;
  logic                cvalid_q, cvalid_d;
  logic [1:0]          cfmt_q, cfmt_d;
  logic [31:0]         cval_q, cval_d;

  mbc_decode u_decode (
    .opcode_i      (req_i.opcode),
    .access_size_i (req_i.access_size),
    .address_i     (req_i.address),
    .write_data_i  (req_i.write_data),
    .ram_o         (dec_ram),
    .ctl_o         (dec_ctl)
  );

  mbc_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (accept && dec_ram.rd),
    .we_i    (accept && dec_ram.we),
    .be_i    (dec_ram.be),
    .addr_i  (dec_ram.widx),
    .wdata_i (dec_ram.wdata),
    .rdata_o (ram_rdata)
  );

  mbc_format u_format (
    .ctl_i       (s1_ctl_q),
    .word_i      (ram_rdata),
    .read_data_o (fmt_rdata)
  );

  // Handshake: the access stage moves on whenever the output slot frees up
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign accept      = req_i.valid && req_i.ready;

  // Next state of the access stage and the output register
  always_comb begin
    s1_ctl_d    = s1_ctl_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    rdata_d     = rdata_q;
    fault_d     = fault_q;
    cvalid_d    = cvalid_q;
    cfmt_d      = cfmt_q;
    cval_d      = cval_q;
    if (advance) begin
      s1_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      rdata_d     = fmt_rdata;
      fault_d     = s1_ctl_q.fault;
      cvalid_d    = s1_ctl_q.con_valid;
      cfmt_d      = s1_ctl_q.con_fmt;
      cval_d      = s1_ctl_q.con_value;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_ctl_d   = dec_ctl;
    end
  end

  // Hold valid flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_ctl_q <= s1_ctl_d;
    rdata_q  <= rdata_d;
    fault_q  <= fault_d;
    cvalid_q <= cvalid_d;
    cfmt_q   <= cfmt_d;
    cval_q   <= cval_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.read_data      = rdata_q;
  assign rsp_o.fault          = fault_q;
  assign rsp_o.console_valid  = cvalid_q;
  assign rsp_o.console_format = cfmt_q;
  assign rsp_o.console_value  = cval_q;

endmodule

FILE: test/tb_memory_bus_with_console_mmio.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_memory_bus_with_console_mmio
// Self-checking bench for the memory bus with console decode. Bus accesses
// are sent over the request channel and every response is compared with a
// local predictor. The predictor keeps a mirror of the RAM and only aims
// loads at bytes that were stored before. The run covers directed console,
// range, lane and alignment cases. It then sends random traffic with bursts
// of idle cycles on both channels, a long response hold and a gap-free tail.
// ----------------------------------------------------------------------------
module tb_memory_bus_with_console_mmio;
  import mbc_pkg::*;

  localparam int unsigned   CLK_PERIOD       = 10;
  localparam int unsigned   RESET_CYCLES     = 8;
  localparam int unsigned   LONG_HOLD_CYCLES = 80;
  localparam int unsigned   DRAIN_CYCLES     = 8;
  localparam int unsigned   MAX_PRINTED      = 100;
  localparam longint        WATCHDOG_NS      = 5_000_000;
  localparam logic [31:0]   RAM_SPAN         = 32'd1 << RAM_ADDR_BITS;

  typedef struct {
    opcode_e     op;
    size_e       size;
    logic [31:0] addr;
    logic [31:0] data;
  } bus_access_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] read_data;
    logic        fault;
    logic        con_valid;
    con_fmt_e    con_fmt;
    logic [31:0] con_value;
  } bus_response_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mbc_req_if req_bus ();
  mbc_rsp_if rsp_bus ();

  memory_bus_with_console_mmio dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // RAM mirror: word content and which byte lanes hold stored data
  logic [31:0]   ram_mirror [int unsigned];
  logic [3:0]    ram_stored [int unsigned];
  int unsigned   stored_words[$];

  bus_response_t expected_responses[$];

  bit          src_gaps_on;
  bit          rsp_stalls_on;
  bit          long_hold_req;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned responses_checked;
  int unsigned faults_expected;
  int unsigned console_writes;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Address decode helpers
  // --------------------------------------------------------------------------
  function automatic bit is_console(logic [31:0] a);
    return a == CON_CHAR || a == CON_DEC || a == CON_HEX;
  endfunction

  function automatic bit in_ram(logic [31:0] a);
    return a >= RAM_BASE && (a - RAM_BASE) < RAM_SPAN;
  endfunction

  function automatic logic [31:0] ram_addr(int unsigned widx, int unsigned lane);
    return RAM_BASE + 32'(widx << 2) + 32'(lane);
  endfunction

  function automatic bus_access_t make_access(opcode_e op, size_e size,
                                              logic [31:0] addr, logic [31:0] data);
    bus_access_t a;
    a.op   = op;
    a.size = size;
    a.addr = addr;
    a.data = data;
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: update the mirror and work out the response of one access
  // --------------------------------------------------------------------------
  function automatic void store_lanes(int unsigned widx, logic [3:0] be,
                                      logic [31:0] lanes);
    if (!ram_stored.exists(widx)) begin
      ram_stored[widx] = 4'h0;
      ram_mirror[widx] = '0;
      stored_words.push_back(widx);
    end
    for (int i = 0; i < 4; i++) begin
      if (be[i]) ram_mirror[widx][8*i +: 8] = lanes[8*i +: 8];
    end
    ram_stored[widx] |= be;
  endfunction

  function automatic bus_response_t predict_response(bus_access_t a);
    bus_response_t r;
    logic [31:0]   off;
    logic [31:0]   word;
    logic [7:0]    b8;
    logic [15:0]   h16;
    int unsigned   widx;
    r.addr      = a.addr;
    r.read_data = '0;
    r.fault     = 1'b0;
    r.con_valid = 1'b0;
    r.con_fmt   = FMT_CHAR;
    r.con_value = '0;
    if (is_console(a.addr)) begin
      // Console window: writes print, reads return zero, size is ignored
      if (a.op == OP_WRITE) begin
        r.con_valid = 1'b1;
        r.con_fmt   = (a.addr == CON_CHAR) ? FMT_CHAR :
                      (a.addr == CON_DEC)  ? FMT_DEC  : FMT_HEX;
        r.con_value = a.data;
        console_writes++;
      end
    end else if (!in_ram(a.addr)) begin
      r.fault = 1'b1;
    end else begin
      off  = a.addr - RAM_BASE;
      widx = off[RAM_ADDR_BITS-1:2];
      word = ram_mirror.exists(widx) ? ram_mirror[widx] : '0;
      b8   = 8'(word >> {off[1:0], 3'b000});
      h16  = 16'(word >> {off[1:0], 3'b000});
      case (a.size)
        SZ_WORD: begin
          if (off[1:0] != 2'b00) r.fault = 1'b1;
          else if (a.op == OP_WRITE) store_lanes(widx, 4'hF, a.data);
          else r.read_data = word;
        end
        SZ_HALF: begin
          if (off[0]) r.fault = 1'b1;
          else if (a.op == OP_WRITE) store_lanes(widx, 4'b0011 << off[1:0], {2{a.data[15:0]}});
          else r.read_data = {{16{h16[15]}}, h16};
        end
        SZ_BYTE: begin
          if (a.op == OP_WRITE) store_lanes(widx, 4'b0001 << off[1:0], {4{a.data[7:0]}});
          else r.read_data = {{24{b8[7]}}, b8};
        end
        default: begin
          // Unknown size: a write is dropped silently, a read faults
          if (a.op == OP_READ) r.fault = 1'b1;
        end
      endcase
    end
    if (r.fault) faults_expected++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random access generation
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_store_word();
    if (stored_words.size() > 0 && $urandom_range(0, 1) == 1)
      return stored_words[$urandom_range(0, stored_words.size() - 1)];
    return $urandom_range(0, RAM_WORDS - 1);
  endfunction

  function automatic int unsigned pick_load_word();
    return stored_words[$urandom_range(0, stored_words.size() - 1)];
  endfunction

  function automatic int unsigned aligned_lane(size_e size);
    case (size)
      SZ_WORD: return 0;
      SZ_HALF: return 2 * $urandom_range(0, 1);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic int unsigned misaligned_lane(size_e size);
    if (size == SZ_WORD) return $urandom_range(1, 3);
    return 1 + 2 * $urandom_range(0, 1);
  endfunction

  // Aim a load at stored bytes only; fall back to a byte load if needed
  function automatic bus_access_t make_load(size_e size);
    int unsigned widx;
    int unsigned lane;
    logic [3:0]  be;
    widx = pick_load_word();
    be   = ram_stored[widx];
    lane = $urandom_range(0, 3);
    case (size)
      SZ_WORD: begin
        if (be == 4'hF) lane = 0;
        else size = SZ_BYTE;
      end
      SZ_HALF: begin
        lane = lane & 2;
        if (be[lane +: 2] != 2'b11) lane = lane ^ 2;
        if (be[lane +: 2] != 2'b11) size = SZ_BYTE;
      end
      default: ;
    endcase
    if (size == SZ_BYTE) begin
      while (!be[lane]) lane = (lane + 1) % 4;
    end
    return make_access(OP_READ, size, ram_addr(widx, lane), $urandom());
  endfunction

  function automatic logic [31:0] pick_unmapped_address();
    logic [31:0] a;
    case ($urandom_range(0, 4))
      0:       a = RAM_BASE - 32'($urandom_range(1, 64));
      1:       a = RAM_BASE + RAM_SPAN + 32'($urandom_range(0, 64));
      2:       a = CON_CHAR + 32'($urandom_range(1, 15));
      3:       a = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: a = $urandom();
    endcase
    while (is_console(a) || in_ram(a)) a = $urandom();
    return a;
  endfunction

  function automatic bus_access_t next_random_access();
    int unsigned pick;
    size_e       size;
    size_e       any_size;
    opcode_e     op;
    logic [31:0] data;
    logic [31:0] con_addr;
    pick     = $urandom_range(0, 99);
    size     = size_e'($urandom_range(0, 2));
    any_size = size_e'($urandom_range(0, 3));
    op       = opcode_e'($urandom_range(0, 1));
    data     = $urandom();
    if (stored_words.size() == 0 && pick >= 35) pick = 0;
    // Mostly well-formed stores and loads, the rest is noise
    if (pick < 35)
      return make_access(OP_WRITE, size, ram_addr(pick_store_word(), aligned_lane(size)), data);
    if (pick < 70)
      return make_load(size);
    size = ($urandom_range(0, 1) == 1) ? SZ_HALF : SZ_WORD;
    if (pick < 75)
      return make_access(OP_WRITE, size, ram_addr(pick_store_word(), misaligned_lane(size)), data);
    if (pick < 79)
      return make_access(OP_READ, size, ram_addr(pick_load_word(), misaligned_lane(size)), data);
    if (pick < 84) begin
      if (op == OP_WRITE)
        return make_access(op, SZ_BAD, ram_addr(pick_store_word(), $urandom_range(0, 3)), data);
      return make_access(op, SZ_BAD, ram_addr(pick_load_word(), $urandom_range(0, 3)), data);
    end
    if (pick < 92) begin
      case ($urandom_range(0, 2))
        0:       con_addr = CON_CHAR;
        1:       con_addr = CON_DEC;
        default: con_addr = CON_HEX;
      endcase
      return make_access(op, any_size, con_addr, data);
    end
    return make_access(op, any_size, pick_unmapped_address(), data);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: optional idle burst, then hold the item until transfer
  // --------------------------------------------------------------------------
  task automatic send_access(input bus_access_t a);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= a.op;
    req_bus.access_size <= a.size;
    req_bus.address     <= a.addr;
    req_bus.write_data  <= a.data;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    expected_responses.push_back(predict_response(a));
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Response receiver: random stall bursts and the requested long hold
  // --------------------------------------------------------------------------
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: compare every transfer with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] addr,
                                 logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] mismatch on %s (address %h): got %h, want %h",
               $time, what, addr, got, want);
  endtask

  always @(posedge clk_i) begin
    bus_response_t want;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("response with nothing pending", '0, rsp_bus.read_data, '0);
      end else begin
        want = expected_responses.pop_front();
        responses_checked++;
        if (rsp_bus.read_data !== want.read_data)
          report_mismatch("read_data", want.addr, rsp_bus.read_data, want.read_data);
        if (rsp_bus.fault !== want.fault)
          report_mismatch("fault", want.addr, 32'(rsp_bus.fault), 32'(want.fault));
        if (rsp_bus.console_valid !== want.con_valid)
          report_mismatch("console_valid", want.addr, 32'(rsp_bus.console_valid),
                          32'(want.con_valid));
        if (rsp_bus.console_format !== want.con_fmt)
          report_mismatch("console_format", want.addr, 32'(rsp_bus.console_format),
                          32'(want.con_fmt));
        if (rsp_bus.console_value !== want.con_value)
          report_mismatch("console_value", want.addr, rsp_bus.console_value,
                          want.con_value);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_console_mmio();
    send_access(make_access(OP_WRITE, SZ_BYTE, CON_CHAR, 32'h0000_0041));
    send_access(make_access(OP_WRITE, SZ_HALF, CON_DEC,  32'hFFFF_FFFF));
    send_access(make_access(OP_WRITE, SZ_BAD,  CON_HEX,  32'hDEAD_BEEF));
    send_access(make_access(OP_READ,  SZ_WORD, CON_CHAR, 32'h0000_0000));
    send_access(make_access(OP_READ,  SZ_BAD,  CON_HEX,  32'h1234_5678));
  endtask

  task automatic test_address_range();
    send_access(make_access(OP_READ,  SZ_WORD, 32'h0000_0000,       32'hFFFF_FFFF));
    send_access(make_access(OP_WRITE, SZ_WORD, 32'hFFFF_FFFF,       32'h0000_0000));
    send_access(make_access(OP_READ,  SZ_BYTE, RAM_BASE - 32'd1,    32'h0000_0000));
    send_access(make_access(OP_WRITE, SZ_BYTE, RAM_BASE + RAM_SPAN, 32'hA5A5_A5A5));
    send_access(make_access(OP_WRITE, SZ_WORD, CON_HEX + 32'd4,     32'h0BAD_F00D));
  endtask

  task automatic test_byte_lanes();
    // Bottom word: sign bits set in some lanes, clear in others
    send_access(make_access(OP_WRITE, SZ_WORD, RAM_BASE,          32'h8081_7F80));
    send_access(make_access(OP_READ,  SZ_WORD, RAM_BASE,          32'h0));
    send_access(make_access(OP_READ,  SZ_BYTE, RAM_BASE,          32'h0));
    send_access(make_access(OP_READ,  SZ_BYTE, RAM_BASE + 32'd1,  32'h0));
    send_access(make_access(OP_READ,  SZ_HALF, RAM_BASE + 32'd2,  32'h0));
    // Top word built from partial stores
    send_access(make_access(OP_WRITE, SZ_HALF, RAM_BASE + RAM_SPAN - 32'd2, 32'h1234_F00D));
    send_access(make_access(OP_WRITE, SZ_BYTE, RAM_BASE + RAM_SPAN - 32'd4, 32'hFFFF_FF7F));
    send_access(make_access(OP_WRITE, SZ_BYTE, RAM_BASE + RAM_SPAN - 32'd3, 32'h0000_0080));
    send_access(make_access(OP_READ,  SZ_HALF, RAM_BASE + RAM_SPAN - 32'd4, 32'h0));
    send_access(make_access(OP_READ,  SZ_WORD, RAM_BASE + RAM_SPAN - 32'd4, 32'h0));
  endtask

  task automatic test_alignment_and_size();
    // Misaligned or unknown-size stores must leave the word untouched
    send_access(make_access(OP_WRITE, SZ_WORD, RAM_BASE + 32'd1, 32'hFFFF_FFFF));
    send_access(make_access(OP_WRITE, SZ_HALF, RAM_BASE + 32'd3, 32'h0000_0000));
    send_access(make_access(OP_WRITE, SZ_BAD,  RAM_BASE,         32'h0000_0000));
    send_access(make_access(OP_READ,  SZ_HALF, RAM_BASE + 32'd1, 32'h0));
    send_access(make_access(OP_READ,  SZ_BAD,  RAM_BASE,         32'h0));
    send_access(make_access(OP_READ,  SZ_WORD, RAM_BASE,         32'h0));
  endtask

  task automatic test_random_traffic(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // Reshuffle the idle pattern now and then, sometimes to none at all
      if (i % 100 == 0) begin
        src_gaps_on   = ($urandom_range(0, 2) != 0);
        rsp_stalls_on = ($urandom_range(0, 2) != 0);
      end
      send_access(next_random_access());
    end
  endtask

  task automatic test_backpressure();
    src_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (60) send_access(next_random_access());
  endtask

  task automatic test_streaming_tail();
    src_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    repeat (80) send_access(next_random_access());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni              <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.opcode      <= OP_READ;
    req_bus.access_size <= SZ_BYTE;
    req_bus.address     <= '0;
    req_bus.write_data  <= '0;
    src_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    long_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_console_mmio();
    test_address_range();
    test_byte_lanes();
    test_alignment_and_size();
    test_random_traffic(700);
    test_backpressure();
    test_streaming_tail();

    // Drain outstanding responses, then watch for strays
    req_bus.valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d accesses over %0d RAM words: %0d faults, %0d console writes expected.",
             items_sent, stored_words.size(), faults_expected, console_writes);
    $display("Checked %0d responses under idle bursts, a long response hold and a gap-free tail.",
             responses_checked);
    if (error_count == 0) begin
      $display("** memory_bus_with_console_mmio: PASSED **");
    end else begin
      $display("** memory_bus_with_console_mmio: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("Timeout with %0d responses still pending", expected_responses.size());
    $display("** memory_bus_with_console_mmio: FAILED **");
    $finish;
  end

endmodule
